// ===== hw/rtl/gark_pkg.sv =====
// Shared constants, types and the exponent table of the ARD Gaussian kernel block.
package gark_pkg;

    // Point dimensions in use, and the number of coordinate slots that an item carries.
    localparam int DIMS     = 4;
    localparam int MAX_DIMS = 4;

    // Field and datapath widths.
    localparam int COORD_W  = 16;                   // signed Q8.8 coordinate
    localparam int ABS_W    = 16;                   // magnitude of a coordinate difference
    localparam int SQ_W     = 2 * ABS_W;            // squared difference, Q16.16
    localparam int CFG_W    = 16;                   // every register is 16 bits
    localparam int WT_W     = SQ_W + CFG_W;         // weighted square, Q24.24
    localparam int SUM_W    = WT_W + 2;             // sum over up to four lanes
    localparam int ARG_SH   = 9;                    // half of Q24.24, back to Q16.16
    localparam int ARG_W    = 32;                   // saturated argument, Q16.16
    localparam int LOG2E_W  = 17;
    localparam int Y_W      = 33;                   // argument times log2(e), Q17.16
    localparam int INT_W    = Y_W - 16;             // integer part of the exponent
    localparam int FRAC_W   = 16;
    localparam int MANT_W   = 17;                   // 2^-f in Q0.16, up to 1.0
    localparam int AMP2_W   = 2 * CFG_W;
    localparam int PROD_W   = AMP2_W + MANT_W;
    localparam int OUT_W    = 32;
    localparam int IN_DATA_W  = 2 * MAX_DIMS * COORD_W;
    localparam int OUT_DATA_W = OUT_W;

    localparam logic [LOG2E_W-1:0] LOG2E_Q16 = 17'd94548;
    localparam logic [INT_W-1:0]   MAX_SHIFT = 17'd32;

    // Configuration registers.
    localparam int NUM_REGS   = 5;
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_LEN_SQ_0 = 3'd1;
    localparam logic [CFG_W-1:0]      CFG_RESET        = 16'd256;

    // Pipeline stages, from the input side to the output register.
    localparam int ST_DIFF   = 0;
    localparam int ST_SQUARE = 1;
    localparam int ST_WEIGHT = 2;
    localparam int ST_SUM    = 3;
    localparam int ST_SAT    = 4;
    localparam int ST_SPLIT  = 5;
    localparam int ST_INTERP = 6;
    localparam int ST_SCALE  = 7;
    localparam int ST_OUT    = 8;
    localparam int NUM_STAGES = 9;

    typedef logic [DIMS-1:0][CFG_W-1:0] inv_vec_t;
    typedef logic [DIMS-1:0][WT_W-1:0]  wt_vec_t;

    typedef struct packed {
        logic diff;
        logic square;
        logic weight;
    } lane_en_t;

    typedef struct packed {
        logic sum;
        logic sat;
    } merge_en_t;

    typedef struct packed {
        logic split;
        logic interp;
        logic scale;
        logic shift;
    } exp_en_t;

    // 2^(-i/16) in Q0.16, rounded, for i = 0..16.
    function automatic logic [MANT_W-1:0] pow2_tab(input logic [4:0] idx);
        logic [MANT_W-1:0] val;
        case (idx)
            5'd0:    val = 17'd65536;
            5'd1:    val = 17'd62757;
            5'd2:    val = 17'd60097;
            5'd3:    val = 17'd57549;
            5'd4:    val = 17'd55109;
            5'd5:    val = 17'd52773;
            5'd6:    val = 17'd50535;
            5'd7:    val = 17'd48393;
            5'd8:    val = 17'd46341;
            5'd9:    val = 17'd44376;
            5'd10:   val = 17'd42495;
            5'd11:   val = 17'd40693;
            5'd12:   val = 17'd38968;
            5'd13:   val = 17'd37316;
            5'd14:   val = 17'd35734;
            5'd15:   val = 17'd34219;
            5'd16:   val = 17'd32768;
            default: val = 17'd32768;
        endcase
        return val;
    endfunction

endpackage

// ===== hw/rtl/gaussian_ard_kernel_eval_top.sv =====
// Top level of the ARD Gaussian kernel block: configuration registers, lanes and flow control.
//
// The block evaluates amplitude^2 * exp(-0.5 * sum_d (xa_d - xb_d)^2 * inv_len_sq_d) for one
// pair of points per item. The input channel (s_tvalid, s_tready, s_tdata) carries both
// points; the result channel (m_tvalid, m_tready, m_tdata) carries the kernel value in
// unsigned Q16.16. Each dimension has its own lane that forms the difference, the square and
// the length-scale weight; a merging stage sums the lanes and the exponential unit finishes.
// An accepted item passes from the difference register through each stage in turn to the
// output register. Throughput is one item per cycle while m_tready stays high, set by
// the nine-stage pipeline in which every stage holds one item.
// Each stage moves when it is empty or the stage after it moves, so bubbles close up:
// while the receiver holds m_tready low the block keeps accepting items until all nine
// stages are full, and only then drops s_tready.
// The configuration port writes one register per cycle at which cfg_wr_en is high;
// cfg_addr 0 is the amplitude and 1 to 4 the inverse squared length scales. Writes to
// other indexes are ignored, and writes are to happen only while no item is in flight.
// A synchronous, active-low reset empties the pipeline and sets every register to 1.0.
module gaussian_ard_kernel_eval_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Fields from bit 0 up: xa_0, xa_1, xa_2, xa_3, xb_0, xb_1, xb_2, xb_3.
    input  logic [gark_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0 up: kernel_value.
    output logic [gark_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_wr_en,
    input  logic [gark_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [gark_pkg::CFG_W-1:0]       cfg_wdata
);
    import gark_pkg::*;

    logic [CFG_W-1:0]      amplitude_reg;
    inv_vec_t              inv_len_sq_reg;
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] stage_en;
    lane_en_t              lane_en;
    merge_en_t             merge_en;
    exp_en_t               exp_en;
    wt_vec_t               lane_wt;
    logic [ARG_W-1:0]      arg;
    logic [OUT_W-1:0]      kernel_value;

    // Configuration registers. Dimensions beyond the ones in use have no register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amplitude_reg <= CFG_RESET;
            for (int d = 0; d < DIMS; d++) begin
                inv_len_sq_reg[d] <= CFG_RESET;
            end
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_AMPLITUDE) begin
                amplitude_reg <= cfg_wdata;
            end
            for (int d = 0; d < DIMS; d++) begin
                if (cfg_addr == REG_INV_LEN_SQ_0 + CFG_ADDR_W'(d)) begin
                    inv_len_sq_reg[d] <= cfg_wdata;
                end
            end
        end
    end

    // A stage loads when it is empty or its contents move on; the last stage is the
    // output register and moves when the receiver takes the item.
    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next = valid_reg;
        if (stage_en[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign lane_en  = '{diff:   stage_en[ST_DIFF],
                        square: stage_en[ST_SQUARE],
                        weight: stage_en[ST_WEIGHT]};
    assign merge_en = '{sum: stage_en[ST_SUM], sat: stage_en[ST_SAT]};
    assign exp_en   = '{split:  stage_en[ST_SPLIT],
                        interp: stage_en[ST_INTERP],
                        scale:  stage_en[ST_SCALE],
                        shift:  stage_en[ST_OUT]};

    for (genvar d = 0; d < DIMS; d++) begin : g_lane
        gark_lane u_lane (
            .aclk       (aclk),
            .en         (lane_en),
            .xa         (s_tdata[d*COORD_W +: COORD_W]),
            .xb         (s_tdata[(MAX_DIMS+d)*COORD_W +: COORD_W]),
            .inv_len_sq (inv_len_sq_reg[d]),
            .weighted   (lane_wt[d])
        );
    end

    gark_merge u_merge (
        .aclk    (aclk),
        .en      (merge_en),
        .lane_wt (lane_wt),
        .arg     (arg)
    );

    gark_exp u_exp (
        .aclk         (aclk),
        .en           (exp_en),
        .arg          (arg),
        .amplitude    (amplitude_reg),
        .kernel_value (kernel_value)
    );

    assign s_tready = stage_en[ST_DIFF];
    assign m_tvalid = valid_reg[ST_OUT];
    assign m_tdata  = kernel_value;

`ifndef SYNTHESIS
    // A receiver that is ready lets the whole pipeline move, so the input side is open.
    a_ready_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while the output side is ready");

    // An accepted item occupies the first stage at the next edge.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[ST_DIFF])
        else $error("accepted item lost at the first stage");

    // Input is refused only when every stage holds an item and the output is stalled.
    a_refuse_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&valid_reg && !m_tready))
        else $error("input refused with room in the pipeline");

    // An item that is held ahead of the output register is still there at the next edge.
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[ST_SCALE] && !stage_en[ST_OUT]) |=> valid_reg[ST_SCALE])
        else $error("stalled item dropped ahead of the output register");
`endif

endmodule

// ===== hw/rtl/gark_lane.sv =====
// One dimension lane: coordinate difference, its square, and the length-scale weight.
module gark_lane (
    input  logic                         aclk,
    input  gark_pkg::lane_en_t           en,
    input  logic [gark_pkg::COORD_W-1:0] xa,
    input  logic [gark_pkg::COORD_W-1:0] xb,
    input  logic [gark_pkg::CFG_W-1:0]   inv_len_sq,
    output logic [gark_pkg::WT_W-1:0]    weighted
);
    import gark_pkg::*;

    logic signed [COORD_W:0] diff;
    logic [ABS_W-1:0] ad_next, ad_reg;
    logic [SQ_W-1:0]  sq_next, sq_reg;
    logic [WT_W-1:0]  wt_next, wt_reg;

    // The difference of two Q8.8 values needs 17 bits; its magnitude fits 16.
    assign diff    = $signed({xa[COORD_W-1], xa}) - $signed({xb[COORD_W-1], xb});
    assign ad_next = diff[COORD_W] ? ABS_W'(-diff) : diff[ABS_W-1:0];
    assign sq_next = SQ_W'(ad_reg) * SQ_W'(ad_reg);
    assign wt_next = WT_W'(sq_reg) * WT_W'(inv_len_sq);

    always_ff @(posedge aclk) begin
        if (en.diff) begin
            ad_reg <= ad_next;
        end
        if (en.square) begin
            sq_reg <= sq_next;
        end
        if (en.weight) begin
            wt_reg <= wt_next;
        end
    end

    assign weighted = wt_reg;

endmodule

// ===== hw/rtl/gark_merge.sv =====
// Merging stage: sums the lane results and saturates the halved argument.
module gark_merge (
    input  logic                       aclk,
    input  gark_pkg::merge_en_t        en,
    input  gark_pkg::wt_vec_t          lane_wt,
    output logic [gark_pkg::ARG_W-1:0] arg
);
    import gark_pkg::*;

    localparam int HALF_W = SUM_W - ARG_SH;

    logic [SUM_W-1:0]  sum_next, sum_reg;
    logic [HALF_W-1:0] half;
    logic [ARG_W-1:0]  arg_next, arg_reg;

    always_comb begin
        sum_next = '0;
        for (int d = 0; d < DIMS; d++) begin
            sum_next = sum_next + SUM_W'(lane_wt[d]);
        end
    end

    // Half the weighted distance in Q16.16, clamped just under 65536.0.
    assign half     = sum_reg[SUM_W-1:ARG_SH];
    assign arg_next = (|half[HALF_W-1:ARG_W]) ? '1 : half[ARG_W-1:0];

    always_ff @(posedge aclk) begin
        if (en.sum) begin
            sum_reg <= sum_next;
        end
        if (en.sat) begin
            arg_reg <= arg_next;
        end
    end

    assign arg = arg_reg;

endmodule

// ===== hw/rtl/gark_exp.sv =====
// Exponential unit: 2^-y by table and interpolation, amplitude scaling and final shift.
module gark_exp (
    input  logic                       aclk,
    input  gark_pkg::exp_en_t          en,
    input  logic [gark_pkg::ARG_W-1:0] arg,
    input  logic [gark_pkg::CFG_W-1:0] amplitude,
    output logic [gark_pkg::OUT_W-1:0] kernel_value
);
    import gark_pkg::*;

    localparam int YP_W = ARG_W + LOG2E_W;

    logic [YP_W-1:0]   y_prod;
    logic [INT_W-1:0]  n_split_reg, n_interp_reg, n_scale_reg;
    logic [FRAC_W-1:0] f_reg;
    logic [4:0]        idx_lo, idx_hi;
    logic [11:0]       r;
    logic [MANT_W-1:0] t_hi, t_lo, t_diff;
    logic [MANT_W+11:0] corr;
    logic [MANT_W-1:0] m_next, m_reg;
    logic [AMP2_W-1:0] amp2_reg;
    logic [PROD_W-1:0] prod_next, prod_reg;
    logic [PROD_W-1:0] shifted;
    logic [OUT_W-1:0]  res_next, res_reg;

    // Argument times log2(e), truncated to Q17.16.
    assign y_prod = YP_W'(arg) * YP_W'(LOG2E_Q16);

    // Linear interpolation between neighboring sixteenths of an octave.
    assign idx_lo = {1'b0, f_reg[FRAC_W-1:12]};
    assign idx_hi = idx_lo + 5'd1;
    assign r      = f_reg[11:0];
    assign t_hi   = pow2_tab(idx_lo);
    assign t_lo   = pow2_tab(idx_hi);
    assign t_diff = t_hi - t_lo;
    assign corr   = (MANT_W+12)'(t_diff) * (MANT_W+12)'(r);
    assign m_next = t_hi - corr[MANT_W+11:12];

    assign prod_next = PROD_W'(amp2_reg) * PROD_W'(m_reg);

    // The product is below 2^49, so any integer part above 32 shifts it out entirely.
    assign shifted  = prod_reg >> n_scale_reg[5:0];
    assign res_next = (n_scale_reg > MAX_SHIFT) ? '0 : shifted[OUT_W+15:16];

    always_ff @(posedge aclk) begin
        // The amplitude is to change only while the block is idle; the block does not enforce it.
        amp2_reg <= AMP2_W'(amplitude) * AMP2_W'(amplitude);
        if (en.split) begin
            n_split_reg <= y_prod[YP_W-1-(YP_W-16-Y_W) -: INT_W];
            f_reg       <= y_prod[16 +: FRAC_W];
        end
        if (en.interp) begin
            m_reg        <= m_next;
            n_interp_reg <= n_split_reg;
        end
        if (en.scale) begin
            prod_reg    <= prod_next;
            n_scale_reg <= n_interp_reg;
        end
        if (en.shift) begin
            res_reg <= res_next;
        end
    end

    assign kernel_value = res_reg;

endmodule
